@@ design/nau_pkg.sv @@
// Shared types, mode codes and exponent tables for the activation unit.
// No dependencies; every other design file imports this package.
`default_nettype none
package nau_pkg;

    localparam int DataW  = 16;
    localparam int FracW  = 10;
    localparam int ExpW   = 33;              // unsigned Q1.32, holds 1.0
    localparam int NumW   = DataW + ExpW;    // m * A
    localparam int DenW   = ExpW + 1;        // 1.0 + e
    localparam int QuotW  = DataW;
    localparam int MagW   = DataW;
    localparam int IntW   = DataW - FracW;   // integer part of |x|, width
    localparam int IntMax = 1 << (IntW - 1); // largest integer part
    localparam int HalfW  = FracW / 2;
    localparam int LoN    = 1 << HalfW;
    localparam int HiN    = 1 << (FracW - HalfW);

    // Table steps: one upper-fraction step and one LSB, as real values
    localparam real HiStep = 1.0 / HiN;
    localparam real LoStep = 1.0 / (1 << FracW);

    typedef logic [1:0] t_mode;
    localparam t_mode MODE_RELU = 2'd0;
    localparam t_mode MODE_SIG  = 2'd1;
    localparam t_mode MODE_SILU = 2'd2;
    localparam t_mode MODE_PASS = 2'd3;

    typedef logic [ExpW-1:0] t_exp;
    typedef t_exp t_tab_k [0:IntMax];
    typedef t_exp t_tab_hi [0:HiN-1];
    typedef t_exp t_tab_lo [0:LoN-1];

    // Control that travels alongside every stage.
    typedef struct packed {
        logic                    valid;
        t_mode                   mode;
        logic signed [DataW-1:0] x;
        logic                    neg;
    } t_ctl;

    function automatic t_exp f_exp(input real v);
        return t_exp'(longint'($exp(-v) * 4294967296.0));
    endfunction

    function automatic t_tab_k f_tab_k();
        t_tab_k t;
        for (int i = 0; i <= IntMax; i++) begin
            t[i] = f_exp(real'(i));
        end
        return t;
    endfunction

    function automatic t_tab_hi f_tab_hi();
        t_tab_hi t;
        for (int i = 0; i < HiN; i++) begin
            t[i] = f_exp(real'(i) * HiStep);
        end
        return t;
    endfunction

    function automatic t_tab_lo f_tab_lo();
        t_tab_lo t;
        for (int i = 0; i < LoN; i++) begin
            t[i] = f_exp(real'(i) * LoStep);
        end
        return t;
    endfunction

    localparam t_tab_k  EXP_K  = f_tab_k();
    localparam t_tab_hi EXP_HI = f_tab_hi();
    localparam t_tab_lo EXP_LO = f_tab_lo();

endpackage
`default_nettype wire

@@ design/nau_if.sv @@
// Stream and configuration channel interfaces of the activation unit.
// Depends on nau_pkg for widths and the mode type.
`default_nettype none
interface nau_x_if import nau_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [DataW-1:0] x;
    modport source (output valid, output x, input ready);
    modport sink   (input valid, input x, output ready);
endinterface

interface nau_y_if import nau_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [DataW-1:0] y;
    modport source (output valid, output y, input ready);
    modport sink   (input valid, input y, output ready);
endinterface

interface nau_cfg_if import nau_pkg::*; ();
    logic  valid;
    logic  ready;
    t_mode mode;
    modport source (output valid, output mode, input ready);
    modport sink   (input valid, input mode, output ready);
endinterface
`default_nettype wire

@@ design/neural_activation_unit.sv @@
// Elementwise ReLU / sigmoid / SiLU unit, Q5.10 in and out, fully pipelined.
// Depends on nau_pkg and the channel interfaces in nau_if.sv.
//
// Usage:
//  - i_x carries one signed Q5.10 element per transfer; o_y returns one
//    signed Q5.10 result per input, in order.
//  - i_cfg writes the mode register (0 relu, 1 sigmoid, 2 silu, 3 pass
//    x through). Always ready; write it only while the pipe is empty.
//    Each element captures the mode in force at its transfer.
//  - 21 register stages: table lookup, two exponent products,
//    numerator/denominator, 16 restoring division stages (one quotient bit
//    each), and the rounding/output register. o_y.valid rises once the
//    element has passed through all of these registers.
//  - Throughput is one element per clock while o_y is not stalled. The 16-stage divider sets the
//    depth; each stage is one 50-bit compare and subtract.
//  - e^-|t| is built as e^-k * e^-(hi/32) * e^-(lo/1024) from three small
//    constant tables in Q1.32; the quotient rounds half up on magnitude.
//  - When o_y stalls, the whole pipe holds, bubbles included, so i_x.ready
//    drops whenever the output register is full and not taken.
//  - Reset (synchronous, active low) clears mode to relu and all valids.
`default_nettype none
module neural_activation_unit
    import nau_pkg::*;
(
    input  wire      i_clk,
    input  wire      i_rst_n,
    nau_x_if.sink    i_x,
    nau_y_if.source  o_y,
    nau_cfg_if.sink  i_cfg
);

    localparam int NStg = QuotW;

    t_mode r_mode;
    logic  w_en;

    // Stage 1: lookups
    t_ctl               r_c1;
    logic [MagW-1:0]    r_mag1;
    t_exp               r_ek1, r_ea1, r_eb1;
    // Stage 2: fraction product
    t_ctl               r_c2;
    logic [MagW-1:0]    r_mag2;
    t_exp               r_ek2, r_p2;
    // Stage 3: full exponent
    t_ctl               r_c3;
    logic [MagW-1:0]    r_mag3;
    t_exp               r_e3;
    // Stage 4: numerator and denominator
    t_ctl               r_c4;
    logic [NumW-1:0]    r_num4;
    logic [DenW-1:0]    r_den4;
    // Divider stages
    t_ctl               r_dc   [0:NStg-1];
    logic [NumW-1:0]    r_rem  [0:NStg-1];
    logic [DenW-1:0]    r_den  [0:NStg-1];
    logic [QuotW-1:0]   r_quo  [0:NStg-1];
    // Output
    logic                    r_ov;
    logic signed [DataW-1:0] r_y;
    t_mode                   r_omode;

    // Advance everything when the output is empty or being taken.
    assign w_en        = !r_ov || o_y.ready;
    assign i_x.ready   = w_en;
    assign i_cfg.ready = 1'b1;
    assign o_y.valid   = r_ov;
    assign o_y.y       = r_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_RELU;
        end else if (i_cfg.valid) begin
            r_mode <= i_cfg.mode;
        end
    end

    // Stage 1
    logic              n_neg1;
    logic [MagW-1:0]   n_mag1;
    logic [IntW-1:0]   n_k1;
    always_comb begin
        n_neg1 = i_x.x[DataW-1];
        n_mag1 = n_neg1 ? MagW'(-i_x.x) : MagW'(i_x.x);
        n_k1   = n_mag1[MagW-1:FracW];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1.valid <= 1'b0;
        end else if (w_en) begin
            r_c1.valid <= i_x.valid;
        end
        if (w_en) begin
            r_c1.mode <= r_mode;
            r_c1.x    <= i_x.x;
            r_c1.neg  <= n_neg1;
            r_mag1    <= n_mag1;
            // integer part reaches IntMax only for the most negative x
            r_ek1     <= EXP_K[n_k1];
            r_ea1     <= EXP_HI[n_mag1[FracW-1:HalfW]];
            r_eb1     <= EXP_LO[n_mag1[HalfW-1:0]];
        end
    end

    // Rounded Q1.32 product
    function automatic t_exp f_mulq(input t_exp a, input t_exp b);
        logic [2*ExpW-1:0] p;
        p = (2*ExpW)'(a) * (2*ExpW)'(b) + (2*ExpW)'(64'd1 << 31);
        return t_exp'(p >> 32);
    endfunction

    // Stage 2
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c2.valid <= 1'b0;
        end else if (w_en) begin
            r_c2.valid <= r_c1.valid;
        end
        if (w_en) begin
            r_c2.mode <= r_c1.mode;
            r_c2.x    <= r_c1.x;
            r_c2.neg  <= r_c1.neg;
            r_mag2    <= r_mag1;
            r_ek2     <= r_ek1;
            r_p2      <= f_mulq(r_ea1, r_eb1);
        end
    end

    // Stage 3
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c3.valid <= 1'b0;
        end else if (w_en) begin
            r_c3.valid <= r_c2.valid;
        end
        if (w_en) begin
            r_c3.mode <= r_c2.mode;
            r_c3.x    <= r_c2.x;
            r_c3.neg  <= r_c2.neg;
            r_mag3    <= r_mag2;
            r_e3      <= f_mulq(r_p2, r_ek2);
        end
    end

    // Stage 4: num = m * A, den = 1 + e
    localparam t_exp OneQ = t_exp'(64'd1 << 32);
    logic [MagW-1:0] n_m4;
    t_exp            n_a4;
    always_comb begin
        n_m4 = (r_c3.mode == MODE_SIG) ? MagW'(1 << FracW) : r_mag3;
        n_a4 = r_c3.neg ? r_e3 : OneQ;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c4.valid <= 1'b0;
        end else if (w_en) begin
            r_c4.valid <= r_c3.valid;
        end
        if (w_en) begin
            r_c4.mode <= r_c3.mode;
            r_c4.x    <= r_c3.x;
            r_c4.neg  <= r_c3.neg;
            r_num4    <= NumW'(n_m4) * NumW'(n_a4);
            r_den4    <= DenW'(OneQ) + DenW'(r_e3);
        end
    end

    // Restoring divider, one quotient bit per stage, MSB first
    genvar g;
    generate
        for (g = 0; g < NStg; g++) begin : g_div
            t_ctl               w_c;
            logic [NumW-1:0]    w_rem;
            logic [DenW-1:0]    w_den;
            logic [QuotW-1:0]   w_quo;
            logic [NumW:0]      w_trial;
            logic               w_fit;
            if (g == 0) begin : g_first
                assign w_c   = r_c4;
                assign w_rem = r_num4;
                assign w_den = r_den4;
                assign w_quo = '0;
            end else begin : g_next
                assign w_c   = r_dc[g-1];
                assign w_rem = r_rem[g-1];
                assign w_den = r_den[g-1];
                assign w_quo = r_quo[g-1];
            end
            assign w_trial = (NumW+1)'(w_den) << (NStg - 1 - g);
            assign w_fit   = (NumW+1)'(w_rem) >= w_trial;

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_dc[g].valid <= 1'b0;
                end else if (w_en) begin
                    r_dc[g].valid <= w_c.valid;
                end
                if (w_en) begin
                    r_dc[g].mode <= w_c.mode;
                    r_dc[g].x    <= w_c.x;
                    r_dc[g].neg  <= w_c.neg;
                    r_den[g]     <= w_den;
                    r_rem[g]     <= w_fit ? NumW'((NumW+1)'(w_rem) - w_trial) : w_rem;
                    r_quo[g]     <= w_quo | (w_fit ? QuotW'(1 << (NStg - 1 - g))
                                                   : QuotW'(0));
                end
            end
        end
    endgenerate

    // Rounding and function select
    t_ctl                    w_lc;
    logic                    n_rnd;
    logic [QuotW-1:0]        n_q;
    logic signed [DataW-1:0] n_y;
    always_comb begin
        w_lc  = r_dc[NStg-1];
        n_rnd = {r_rem[NStg-1], 1'b0} >= (NumW+1)'(r_den[NStg-1]);
        n_q   = r_quo[NStg-1] + QuotW'(n_rnd);
        case (w_lc.mode)
            MODE_RELU: n_y = (w_lc.x > 0) ? w_lc.x : '0;
            MODE_SIG:  n_y = DataW'(n_q);
            MODE_SILU: n_y = w_lc.neg ? -DataW'(n_q) : DataW'(n_q);
            default:   n_y = w_lc.x;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_en) begin
            r_ov <= w_lc.valid;
        end
        if (w_en) begin
            r_y     <= n_y;
            r_omode <= w_lc.mode;
        end
    end

    // Range checks on delivered results, and a check that a stalled item is held
    a_relu_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && r_omode == MODE_RELU |-> r_y >= 0)
        else $error("relu result negative");

    a_sig_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && r_omode == MODE_SIG |-> r_y >= 0 && r_y <= 16'sd1024)
        else $error("sigmoid result out of range");

    a_silu_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && r_omode == MODE_SILU |-> r_y >= -16'sd300)
        else $error("silu result below its minimum");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dc[NStg-1].valid && r_ov && !o_y.ready |=> r_dc[NStg-1].valid && r_ov)
        else $error("stalled divider item lost");

endmodule
`default_nettype wire
